@@ sv/swspd_pkg.sv @@
`default_nettype none

package swspd_pkg;

  // Frame and pulse geometry
  localparam int FrameBits  = 40;
  localparam int CountWidth = $clog2(FrameBits + 1);
  localparam int TimeWidth  = 16;
  localparam int CfgWidth   = 16;
  localparam int ByteWidth  = 8;

  // Configuration reset values, in timer cycles
  localparam logic [CfgWidth-1:0] OneThresholdRst = CfgWidth'(50 * 8);
  localparam logic [CfgWidth-1:0] StartMaxRst     = CfgWidth'(95 * 8);
  localparam logic [CfgWidth-1:0] StartMinRst     = CfgWidth'(75 * 8);

  // Queue between classifier and frame assembler
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    REG_ONE_THRESHOLD = 2'd0,
    REG_START_MIN     = 2'd1,
    REG_START_MAX     = 2'd2
  } reg_idx_e;

  typedef enum logic [0:0] {
    ACT_ARM   = 1'b0,
    ACT_PULSE = 1'b1
  } action_e;

  // One classified input beat
  typedef struct packed {
    action_e kind;
    logic    in_window;
    logic    bit_val;
  } op_t;

  // One decoded frame: bytes in arrival order, lowest byte first
  typedef struct packed {
    logic                 err;
    logic [FrameBits-1:0] data;
  } res_t;

endpackage

`default_nettype wire

@@ sv/swspd_front.sv @@
`default_nettype none

module swspd_front import swspd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [CfgWidth-1:0]  cfg_data_i,
  input  wire logic                 action_i,
  input  wire logic [TimeWidth-1:0] high_time_i,
  output op_t                       op_o
);

  logic [CfgWidth-1:0] one_thr_q;
  logic [CfgWidth-1:0] start_min_q;
  logic [CfgWidth-1:0] start_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_thr_q   <= OneThresholdRst;
      start_min_q <= StartMinRst;
      start_max_q <= StartMaxRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ONE_THRESHOLD: one_thr_q   <= cfg_data_i;
        REG_START_MIN:     start_min_q <= cfg_data_i;
        REG_START_MAX:     start_max_q <= cfg_data_i;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // Classify the pulse against the start window and the bit threshold
  always_comb begin
    op_o.kind      = action_e'(action_i);
    op_o.in_window = (high_time_i >= start_min_q) && (high_time_i <= start_max_q);
    op_o.bit_val   = high_time_i > one_thr_q;
  end

endmodule

`default_nettype wire

@@ sv/swspd_queue.sv @@
`default_nettype none

module swspd_queue import swspd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       head_o
);

  op_t                  mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q;
  logic [QueueAw-1:0]   rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign ready_o = cnt_q != QueueCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/swspd_back.sv @@
`default_nettype none

module swspd_back import swspd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic op_valid_i,
  input  wire op_t  op_i,
  output logic      op_pop_o,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);

  logic                  in_payload_q, in_payload_d;
  logic [CountWidth-1:0] bit_count_q, bit_count_d;
  logic [FrameBits-1:0]  bit_shift_q, bit_shift_d;
  logic                  res_valid_q;
  res_t                  res_q;

  logic                  frame_done;
  logic                  slot_free;
  logic [ByteWidth-1:0]  sum;

  assign slot_free = !res_valid_q || res_ready_i;

  // Fortieth data bit closes the frame
  assign frame_done = (op_i.kind == ACT_PULSE) && in_payload_q
                    && (bit_count_q == CountWidth'(FrameBits - 1));

  // Stall the head only when it would produce a frame and the output slot is busy
  assign op_pop_o = op_valid_i && (!frame_done || slot_free);

  always_comb begin
    in_payload_d = in_payload_q;
    bit_count_d  = bit_count_q;
    bit_shift_d  = bit_shift_q;
    case (op_i.kind)
      ACT_ARM: begin
        in_payload_d = 1'b0;
        bit_count_d  = '0;
        bit_shift_d  = '0;
      end
      ACT_PULSE: begin
        if (bit_count_q < CountWidth'(FrameBits)) begin
          if (!in_payload_q) begin
            if (op_i.in_window) begin
              in_payload_d = 1'b1;
              bit_count_d  = '0;
              bit_shift_d  = '0;
            end
          end else begin
            bit_shift_d = {bit_shift_q[FrameBits-2:0], op_i.bit_val};
            bit_count_d = bit_count_q + CountWidth'(1);
            if (frame_done) begin
              in_payload_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign sum = bit_shift_d[39:32] + bit_shift_d[31:24]
             + bit_shift_d[23:16] + bit_shift_d[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      bit_count_q  <= '0;
      bit_shift_q  <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (op_pop_o) begin
        in_payload_q <= in_payload_d;
        bit_count_q  <= bit_count_d;
        bit_shift_q  <= bit_shift_d;
      end
      if (op_pop_o && frame_done) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Byte order on the output: first received byte lowest
  always_ff @(posedge clk_i) begin
    if (op_pop_o && frame_done) begin
      res_q.data <= {bit_shift_d[7:0], bit_shift_d[15:8], bit_shift_d[23:16],
                     bit_shift_d[31:24], bit_shift_d[39:32]};
      res_q.err  <= sum != bit_shift_d[7:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ sv/single_wire_sensor_pulse_decoder.sv @@
`default_nettype none

// Pulse decoder for a single-wire humidity/temperature sensor.
// Input stream: one beat per event. tuser = action (0 arm, 1 pulse ended),
// tdata = measured high-pulse width in timer cycles. An arm clears the frame;
// after it, a pulse inside [start_min, start_max] opens the frame, and each of
// the next forty pulses is a data bit (1 when wider than one_threshold).
// Output stream: one beat per completed frame. tdata holds the five bytes in
// arrival order, first byte lowest; tuser flags a checksum mismatch.
// Config channel: index 0 one_threshold, 1 start_min, 2 start_max; always
// ready; write only while the block is idle. Other indexes are dropped.
// Throughput: one input beat per cycle while the queue has room. A beat is
// classified into a four-entry queue and applied from its head by the frame
// assembler; with the queue empty, the closing bit's frame passes through a
// queue entry and then the output register before it is on the output.
// When the output stalls, the frame waits in the output register, the
// assembler holds the next frame-closing op, and the queue absorbs up to four
// beats before s_axis_tready drops. Reset clears the frame state, empties
// the queue and output, and loads the threshold defaults (400, 600, 760).

module single_wire_sensor_pulse_decoder import swspd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Config write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [CfgWidth-1:0]    cfg_data_i,
  // Pulse input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TimeWidth-1:0]   s_axis_tdata,  // [15:0] high_time
  input  wire logic                   s_axis_tuser,  // [0] action
  // Frame output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] humidity_int, [15:8] humidity_dec, [23:16] temp_int,
  // [31:24] temp_dec, [39:32] checksum_rx
  output logic [FrameBits-1:0]        m_axis_tdata,
  output logic                        m_axis_tuser   // [0] checksum_error
);

  op_t  front_op;
  op_t  head_op;
  logic q_ready;
  logic q_valid;
  logic q_pop;
  logic q_push;
  res_t res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready;

  // Classify each beat against the current thresholds
  swspd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (s_axis_tuser),
    .high_time_i (s_axis_tdata),
    .op_o        (front_op)
  );

  // Decouple the input side from output stalls
  swspd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (front_op),
    .ready_o   (q_ready),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_op)
  );

  // Track the frame and emit it on the fortieth bit
  swspd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .op_pop_o    (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.err;

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // A new frame only appears after an op was applied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(q_pop))
    else $error("output valid without an applied op");

  // Error flag matches the delivered bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ==
      ((m_axis_tdata[7:0] + m_axis_tdata[15:8] + m_axis_tdata[23:16]
        + m_axis_tdata[31:24]) != m_axis_tdata[39:32])))
    else $error("checksum flag inconsistent with frame");

endmodule

`default_nettype wire
